// ===== src/frame_difference_motion_mask_unit_macros.svh =====
// Assertion macros for the frame difference motion mask unit.
// Included by fdmm_front, the RTL file that carries concurrent checks; no dependencies.
`ifndef FRAME_DIFFERENCE_MOTION_MASK_UNIT_MACROS_SVH
`define FRAME_DIFFERENCE_MOTION_MASK_UNIT_MACROS_SVH
`ifndef SYNTH
`define FDMM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FDMM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `FDMM_ASSERT(lbl, clk, rst_n, !(cond), msg)
`else
`define FDMM_ASSERT(lbl, clk, rst_n, prop, msg)
`define FDMM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== src/fdmm_pkg.sv =====
// Shared constants and types of the frame difference motion mask unit.
// No dependencies.
`default_nettype none
package fdmm_pkg;

  localparam int unsigned FRAME_WIDTH  = 640;
  localparam int unsigned FRAME_HEIGHT = 480;
  localparam int unsigned PIXEL_COUNT  = FRAME_WIDTH * FRAME_HEIGHT;

  localparam int unsigned POS_W  = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam int unsigned FILL_W = $clog2(PIXEL_COUNT + 1);

  localparam int unsigned CHAN_W = 8;
  localparam int unsigned PIX_W  = 3 * CHAN_W;
  localparam int unsigned THR_W  = 10;

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned QPTR_W  = $clog2(Q_DEPTH);
  localparam int unsigned QCNT_W  = $clog2(Q_DEPTH + 1);

  // current pixel with the stored pixel of the same position
  typedef struct packed {
    logic [PIX_W-1:0] cur;
    logic [PIX_W-1:0] old;
    logic             last;
  } pair_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
  } fifo_stat_t;

endpackage
`default_nettype wire

// ===== src/fdmm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Read during write to the same address returns the old word. No dependencies.
`default_nettype none
module fdmm_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== src/fdmm_fifo.sv =====
// Short queue of pixel pairs between the front and back parts.
// Depends on fdmm_pkg.
`default_nettype none
module fdmm_fifo (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire fdmm_pkg::pair_t     push_data_i,
  input  wire logic                pop_i,
  output fdmm_pkg::pair_t          head_o,
  output fdmm_pkg::fifo_stat_t     stat_o
);

  localparam int unsigned QPTR_W = fdmm_pkg::QPTR_W;
  localparam int unsigned QCNT_W = fdmm_pkg::QCNT_W;

  fdmm_pkg::pair_t   slot_q [fdmm_pkg::Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(fdmm_pkg::Q_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o       = slot_q[rd_ptr_q];
  assign stat_o.count = count_q;
  assign stat_o.empty = (count_q == '0);

endmodule
`default_nettype wire

// ===== src/fdmm_front.sv =====
// Front part: pixel counter, frame store read-modify-write and fill tracking.
// Pairs each pixel with its stored predecessor and pushes it to the queue.
// Depends on fdmm_pkg, fdmm_ram and the assertion macro header.
`default_nettype none
`include "frame_difference_motion_mask_unit_macros.svh"
module fdmm_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [fdmm_pkg::PIX_W-1:0]    in_rgb_i,
  input  wire logic                          in_start_i,
  input  wire fdmm_pkg::fifo_stat_t          q_stat_i,
  output logic                               push_o,
  output fdmm_pkg::pair_t                    push_data_o
);

  localparam int unsigned POS_W  = fdmm_pkg::POS_W;
  localparam int unsigned FILL_W = fdmm_pkg::FILL_W;
  localparam int unsigned PIX_W  = fdmm_pkg::PIX_W;
  localparam int unsigned QCNT_W = fdmm_pkg::QCNT_W;

  logic              accept;
  logic [POS_W-1:0]  pos_q, pos_d, pos_sel;
  logic [FILL_W-1:0] fill_q, fill_d, pos_inc;
  logic              last;
  logic              fwd;
  logic [PIX_W-1:0]  ram_rdata;
  logic [PIX_W-1:0]  old_pix;

  logic              f_valid_q;
  logic [POS_W-1:0]  f_pos_q;
  logic [PIX_W-1:0]  f_rgb_q;
  logic              f_last_q;
  logic              f_known_q;
  logic              f_fwd_q;
  logic [PIX_W-1:0]  f_fwd_rgb_q;

  // one slot is held back for the beat in the read stage
  assign in_ready_o = (q_stat_i.count + QCNT_W'(f_valid_q)) < QCNT_W'(fdmm_pkg::Q_DEPTH);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    pos_sel = in_start_i ? '0 : pos_q;
    last    = (pos_sel == POS_W'(fdmm_pkg::PIXEL_COUNT - 1));
    pos_inc = FILL_W'(pos_sel) + FILL_W'(1);
    pos_d   = pos_q;
    fill_d  = fill_q;
    if (accept) begin
      pos_d = last ? '0 : pos_sel + POS_W'(1);
      if (pos_inc > fill_q) begin
        fill_d = pos_inc;
      end
    end
    fwd = f_valid_q && (f_pos_q == pos_sel);
  end

  // written positions always form a prefix, so the fill count stands in for a clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      fill_q    <= '0;
      f_valid_q <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      fill_q    <= fill_d;
      f_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f_pos_q     <= pos_sel;
      f_rgb_q     <= in_rgb_i;
      f_last_q    <= last;
      f_known_q   <= FILL_W'(pos_sel) < fill_q;
      f_fwd_q     <= fwd;
      f_fwd_rgb_q <= f_rgb_q;
    end
  end

  fdmm_ram #(
    .WIDTH (PIX_W),
    .DEPTH (fdmm_pkg::PIXEL_COUNT)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (f_valid_q),
    .waddr_i (f_pos_q),
    .wdata_i (f_rgb_q),
    .re_i    (accept),
    .raddr_i (pos_sel),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (f_fwd_q) begin
      old_pix = f_fwd_rgb_q;
    end else if (f_known_q) begin
      old_pix = ram_rdata;
    end else begin
      old_pix = '0;
    end
  end

  assign push_o           = f_valid_q;
  assign push_data_o.cur  = f_rgb_q;
  assign push_data_o.old  = old_pix;
  assign push_data_o.last = f_last_q;

  `FDMM_ASSERT(a_pos_range, clk_i, rst_ni, FILL_W'(pos_q) < FILL_W'(fdmm_pkg::PIXEL_COUNT), "pixel counter out of range")
  `FDMM_ASSERT(a_fill_range, clk_i, rst_ni, fill_q <= FILL_W'(fdmm_pkg::PIXEL_COUNT), "fill count out of range")
  `FDMM_ASSERT(a_accept_stage, clk_i, rst_ni, accept |=> f_valid_q, "accepted beat missing from read stage")
  `FDMM_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, f_valid_q && (q_stat_i.count == QCNT_W'(fdmm_pkg::Q_DEPTH)), "push into full queue")

endmodule
`default_nettype wire

// ===== src/fdmm_back.sv =====
// Back part: squared color distance, threshold compare and the output register.
// Holds the threshold register. Depends on fdmm_pkg.
`default_nettype none
module fdmm_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [fdmm_pkg::THR_W-1:0]    cfg_wdata_i,
  input  wire fdmm_pkg::fifo_stat_t          q_stat_i,
  input  wire fdmm_pkg::pair_t               q_head_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               out_motion_o,
  output logic                               out_last_o
);

  localparam int unsigned CHAN_W = fdmm_pkg::CHAN_W;
  localparam int unsigned THR_W  = fdmm_pkg::THR_W;
  localparam int unsigned SQ_W   = 2 * CHAN_W;
  localparam int unsigned DIST_W = SQ_W + 2;
  localparam int unsigned THR2_W = 2 * THR_W;

  function automatic logic [SQ_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

  logic [THR_W-1:0]  thr_q;
  logic [THR2_W-1:0] thr2_q;

  logic              b1_valid_q, b1_en;
  logic [SQ_W-1:0]   sq_r_q, sq_g_q, sq_b_q;
  logic              b1_last_q;

  logic              o_valid_q, b2_en;
  logic              o_motion_q, o_last_q;
  logic [DIST_W-1:0] dist2;

  assign b2_en = !o_valid_q || out_ready_i;
  assign b1_en = !b1_valid_q || b2_en;
  assign pop_o = !q_stat_i.empty && b1_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= '0;
      thr2_q     <= '0;
      b1_valid_q <= 1'b0;
      o_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      thr2_q <= THR2_W'(thr_q) * THR2_W'(thr_q);
      if (b1_en) begin
        b1_valid_q <= pop_o;
      end
      if (b2_en) begin
        o_valid_q <= b1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      sq_r_q    <= sq_diff(q_head_i.cur[CHAN_W-1:0], q_head_i.old[CHAN_W-1:0]);
      sq_g_q    <= sq_diff(q_head_i.cur[2*CHAN_W-1:CHAN_W], q_head_i.old[2*CHAN_W-1:CHAN_W]);
      sq_b_q    <= sq_diff(q_head_i.cur[3*CHAN_W-1:2*CHAN_W],
                           q_head_i.old[3*CHAN_W-1:2*CHAN_W]);
      b1_last_q <= q_head_i.last;
    end
  end

  assign dist2 = DIST_W'(sq_r_q) + DIST_W'(sq_g_q) + DIST_W'(sq_b_q);

  always_ff @(posedge clk_i) begin
    if (b2_en && b1_valid_q) begin
      o_motion_q <= THR2_W'(dist2) > thr2_q;
      o_last_q   <= b1_last_q;
    end
  end

  assign out_valid_o  = o_valid_q;
  assign out_motion_o = o_motion_q;
  assign out_last_o   = o_last_q;

endmodule
`default_nettype wire

// ===== src/frame_difference_motion_mask_unit.sv =====
// Frame difference motion mask: one motion flag per RGB pixel against the
// previous frame. Top level; depends on fdmm_pkg, fdmm_front, fdmm_fifo, fdmm_back.
//
// Usage:
//   s_axis carries one pixel per beat in scan order; tuser marks the first
//   pixel of a frame and restarts the pixel counter. m_axis returns one beat
//   per pixel: tdata bit 0 is the motion flag, tlast marks the last pixel
//   position of a frame. Motion is set when the squared color distance to the
//   stored pixel exceeds the squared threshold written on cfg_we_i/cfg_wdata_i.
//   Throughput is one pixel per cycle while m_axis_tready holds, set by one read
//   and one write of the frame store each cycle. An input beat passes the
//   store read, queue, squares, and sum and compare stages to its result beat.
//   Reset clears the counter, the threshold and a fill count of written
//   positions; positions not yet written read as black, so there is no
//   clearing pass and input is taken from the first cycle after reset.
//   When m_axis stalls, beats collect in a four-entry queue, the squares stage
//   and the output register; s_axis_tready drops once the queue has no room left.
//   Write the threshold only while no pixel is in flight.
`default_nettype none
module frame_difference_motion_mask_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [23:0]                 s_axis_tdata,  // red, green, blue
  input  wire logic                        s_axis_tuser,  // frame_start
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [7:0]                       m_axis_tdata,  // motion, zero pad
  output logic                             m_axis_tlast,  // frame_end
  input  wire logic                        cfg_we_i,
  input  wire logic [fdmm_pkg::THR_W-1:0]  cfg_wdata_i
);

  logic                 push, pop;
  fdmm_pkg::pair_t      push_data, head;
  fdmm_pkg::fifo_stat_t q_stat;
  logic                 motion;

  fdmm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_rgb_i    (s_axis_tdata),
    .in_start_i  (s_axis_tuser),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  fdmm_fifo u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  fdmm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .q_stat_i     (q_stat),
    .q_head_i     (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_motion_o (motion),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {7'b0, motion};

endmodule
`default_nettype wire
